### rtl/cli_pkg.sv
// Package for the curve linear interpolator: shared constants and types.
// Used by every module in rtl/.
`default_nettype none
package cli_pkg;
  localparam int unsigned MaxPointsDefault = 64;
  localparam int unsigned CountW = 7;
  localparam int unsigned SpanW  = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned DataW  = 32;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    CFG_POINT_COUNT = 1'b0,
    CFG_MIN_SPAN    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_PREV,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } eng_state_e;

  // One classified item handed from the front end to the engine.
  typedef struct packed {
    logic              is_query;
    logic [5:0]        index;
    logic [DataW-1:0]  px;
    logic [DataW-1:0]  py;
    logic [DataW-1:0]  qx;
  } item_t;
endpackage
`default_nettype wire

### rtl/curve_linear_interpolator.sv
// Piecewise linear curve interpolator over up to MaxPoints Q16.16 breakpoints.
// A write is taken from the front queue when the engine is idle and goes straight into
// the breakpoint memory. A query first reads the first breakpoint and ends there when it
// is at or below it; otherwise it scans on, one memory read per breakpoint, and ends when
// it runs past the last one. Else it reads the previous breakpoint and ends when the
// interval is too narrow, or interpolates with the one-bit-per-cycle 64-by-33 divider.
// The engine waits in its output state while the previous result is not yet popped.
// Items queue in a two-entry front queue; one item is worked at a time.
`default_nettype none
module curve_linear_interpolator #(
  parameter int unsigned MaxPoints = cli_pkg::MaxPointsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        operation_i,
  input  wire logic [5:0]                  point_index_i,
  input  wire logic signed [31:0]          point_x_i,
  input  wire logic signed [31:0]          point_y_i,
  input  wire logic signed [31:0]          query_x_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic signed [31:0]               curve_value_o,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_index_i,
  input  wire logic [cli_pkg::CfgW-1:0]    cfg_data_i
);
  import cli_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_take, res_valid;
  logic [CountW-1:0] count_q;
  logic [SpanW-1:0]  span_q;
  logic [DataW-1:0]  res;

  assign in_item = '{is_query: operation_i == OP_QUERY, index: point_index_i,
                     px: point_x_i, py: point_y_i, qx: query_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(1);
      span_q  <= SpanW'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_POINT_COUNT) begin
        count_q <= cfg_data_i[CountW-1:0];
      end else begin
        span_q <= cfg_data_i[SpanW-1:0];
      end
    end
  end

  cli_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .item_i (in_item),
    .valid_o(q_valid),
    .item_o (q_item),
    .take_i (q_take)
  );

  cli_engine #(.MaxPoints(MaxPoints)) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .item_i       (q_item),
    .take_o       (q_take),
    .point_count_i(count_q),
    .min_span_i   (span_q),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop && res_valid)
  );

  assign empty         = !res_valid;
  assign curve_value_o = res;

`ifndef SYNTH
  a_take_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_take |-> q_valid) else $error("engine took from an empty queue");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(curve_value_o)))
    else $error("waiting result changed");
`endif
endmodule
`default_nettype wire

### rtl/cli_front.sv
// Front end: accepts items and queues them for the engine (two-entry queue).
// Depends on cli_pkg.
`default_nettype none
module cli_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                full_o,
  input  wire cli_pkg::item_t item_i,
  output logic                valid_o,
  output cli_pkg::item_t      item_o,
  input  wire logic           take_i
);
  import cli_pkg::*;

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wp_q <= ~wp_q;
      end
      if (do_pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule
`default_nettype wire

### rtl/cli_divider.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 33-bit divisor.
// Depends on cli_pkg.
`default_nettype none
module cli_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [32:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quot_o
);
  import cli_pkg::*;

  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [32:0] dvs_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [33:0] trial;

  assign trial  = {rem_q, quo_q[63]} - {1'b0, dvs_q};
  assign done_o = busy_q && cnt_q == 7'd0;
  assign quot_o = quo_q;

  always_comb begin
    if (!trial[33]) begin
      rem_d = trial[32:0];
      quo_d = {quo_q[62:0], 1'b1};
    end else begin
      rem_d = {rem_q[31:0], quo_q[63]};
      quo_d = {quo_q[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q && cnt_q != 7'd0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd64;
    end else if (busy_q) begin
      if (cnt_q == 7'd0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 7'd1;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/cli_engine.sv
// Back end: breakpoint memory, bracket search, multiply, divide and saturate.
// Depends on cli_pkg and cli_divider.
`default_nettype none
module cli_engine #(
  parameter int unsigned MaxPoints = cli_pkg::MaxPointsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire cli_pkg::item_t               item_i,
  output logic                              take_o,
  input  wire logic [cli_pkg::CountW-1:0]   point_count_i,
  input  wire logic [cli_pkg::SpanW-1:0]    min_span_i,
  output logic                              res_valid_o,
  output logic [cli_pkg::DataW-1:0]         res_o,
  input  wire logic                         res_pop_i
);
  import cli_pkg::*;

  localparam int unsigned AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned KW = AW + 1;

  logic [2*DataW-1:0] mem_q [MaxPoints];
  logic [2*DataW-1:0] rd_q;
  logic [AW-1:0]      raddr;
  logic               ren;

  eng_state_e state_q, state_d;
  logic [KW-1:0] k_q, k_d, n_lim;
  logic signed [DataW-1:0] q_q, xk_q, yk_q;
  logic signed [DataW-1:0] rx, ry;
  logic [32:0] adx_q;
  logic [32:0] mdy_q;
  logic [31:0] dq_q;
  logic        neg_q;
  logic [63:0] prod;
  logic        res_v_q;
  logic [DataW-1:0] res_q, res_d;
  logic        set_res;
  logic        div_start, div_done;
  logic [63:0] quot;
  logic        take;
  logic        is_last;
  logic signed [33:0] dx, dy;
  logic signed [34:0] sum;
  logic        wr_en;

  assign rx = rd_q[2*DataW-1:DataW];
  assign ry = rd_q[DataW-1:0];

  // Clamp the configured count into 1..MaxPoints.
  always_comb begin
    if (point_count_i == '0) begin
      n_lim = KW'(1);
    end else if (32'(point_count_i) > MaxPoints) begin
      n_lim = KW'(MaxPoints);
    end else begin
      n_lim = KW'(point_count_i);
    end
  end

  assign wr_en = take && !item_i.is_query && 32'(item_i.index) < MaxPoints;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AW'(item_i.index)] <= {item_i.px, item_i.py};
    end
    if (ren) begin
      rd_q <= mem_q[raddr];
    end
  end

  assign dx  = 34'(xk_q) - 34'(rx);
  assign dy  = 34'(yk_q) - 34'(ry);
  assign is_last = (k_q + KW'(1)) >= n_lim;

  // The product is formed from registered operands and is captured by the
  // divider when it starts.
  assign prod = 64'(dq_q) * 64'(mdy_q);

  always_comb begin
    sum = 35'(yk_q) - 35'(signed'({1'b0, quot[33:0]}));
    if (neg_q) begin
      sum = 35'(yk_q) + 35'(signed'({1'b0, quot[33:0]}));
    end
    if (quot >= 64'h2_0000_0000) begin
      res_d = neg_q ? 32'h7FFF_FFFF : 32'h8000_0000;
    end else if (sum > 35'sh0_7FFF_FFFF) begin
      res_d = 32'h7FFF_FFFF;
    end else if (sum < -35'sh0_8000_0000) begin
      res_d = 32'h8000_0000;
    end else begin
      res_d = sum[31:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    take      = 1'b0;
    ren       = 1'b0;
    raddr     = '0;
    div_start = 1'b0;
    set_res   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          take = 1'b1;
          if (item_i.is_query) begin
            ren     = 1'b1;
            raddr   = '0;
            k_d     = '0;
            state_d = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        if (q_q <= rx) begin
          state_d = ST_OUT;
        end else if (n_lim == KW'(1)) begin
          state_d = ST_OUT;
        end else begin
          ren     = 1'b1;
          raddr   = AW'(1);
          k_d     = KW'(1);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rx >= q_q) begin
          ren     = 1'b1;
          raddr   = AW'(k_q - KW'(1));
          state_d = ST_PREV;
        end else if (is_last) begin
          state_d = ST_OUT;
        end else begin
          ren     = 1'b1;
          raddr   = AW'(k_q + KW'(1));
          k_d     = k_q + KW'(1);
        end
      end
      ST_PREV: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (adx_q == '0 || adx_q < 33'(min_span_i)) begin
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          set_res = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!res_v_q || res_pop_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign take_o = take;

  // Datapath registers follow the state; yk_q holds the fallback answer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: q_q <= item_i.qx;
      ST_FIRST: yk_q <= ry;
      ST_SCAN: begin
        xk_q <= rx;
        yk_q <= ry;
      end
      ST_PREV: begin
        adx_q <= dx[33] ? 33'(-dx) : 33'(dx);
        mdy_q <= dy[33] ? 33'(-dy) : 33'(dy);
        neg_q <= dy[33] != dx[33];
        dq_q  <= 32'(34'(xk_q) - 34'(q_q));
      end
      ST_DIV: begin
        if (set_res) begin
          yk_q <= res_d;
        end
      end
      default: ;
    endcase
  end

  cli_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod),
    .divisor_i (adx_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // Result register: the engine fills it and moves on while it waits.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!res_v_q || res_pop_i)) begin
      res_q <= yk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (state_q == ST_OUT && (!res_v_q || res_pop_i)) begin
        res_v_q <= 1'b1;
      end else if (res_pop_i) begin
        res_v_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;
endmodule
`default_nettype wire
